FILE: sv/assert_macros.svh
// assertion helpers included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: sv/perw_pkg.sv
package perw_pkg;

	localparam int SUBINT_DEF = 16;
	localparam int SEQ_W      = 7;
	localparam int CNT_W      = 16;
	localparam int TIME_W     = 32;
	localparam int RATE_W     = 7;
	localparam int SUM_W      = 8;
	localparam int NUM_W      = 16;
	localparam int DEN_W      = SUM_W + 1;
	localparam int CFG_W      = 16;

	localparam logic [CFG_W-1:0]  SUBINT_MS_RST = 16'd100;
	localparam logic [RATE_W-1:0] PCT_MAX       = 7'd100;
	localparam logic [NUM_W-1:0]  PCT_X2        = 16'd200;

	typedef struct packed {
		logic [SEQ_W-1:0] first;
		logic [SEQ_W-1:0] last;
		logic [CNT_W-1:0] cnt;
	} entry_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] numer;
		logic [DEN_W-1:0] denom;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

endpackage

FILE: sv/perw_div.sv
module perw_div
	import perw_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEP_W = $clog2(NUM_W);

	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           ge;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				num_q  <= req.numer;
				den_q  <= req.denom;
				rem_q  <= '0;
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				num_q  <= {num_q[NUM_W-2:0], ge};
				rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = num_q;

endmodule

FILE: sv/packet_error_rate_window_top.sv
// Packet error rate over a sliding window of SUBINTERVALS subintervals. Each input transaction
// is one received message (sequence counter in s_tdata[6:0], arrival time in ms in
// s_tdata[38:7]); the block takes one message at a time and holds s_tready low while it works.
// A message inside the open subinterval, or one whose time moved back, passes through
// ST_CHECK and gives no result. A message that closes the subinterval gives one result
// transaction: the window entries are walked one per cycle through a single accumulate
// unit, then, unless the rate is unavailable or the expected count is zero, the rate goes
// through a bit-serial divider at one quotient bit per cycle. The result register lets
// the next message be accepted before the result is taken; a later rollover waits for it.
// cfg_data sets the subinterval length (reset 100 ms) and is always ready.
`include "assert_macros.svh"

module packet_error_rate_window_top
	import perw_pkg::*;
#(
	parameter int SUBINTERVALS = SUBINT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // msg_count[6:0], time_ms[38:7]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // error_rate[6:0]
	output logic        m_tuser,   // unavailable[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int WALK_W = $clog2(SUBINTERVALS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WALK,
		ST_FINAL,
		ST_DIVGO,
		ST_DIVWAIT,
		ST_OUT
	} state_t;

	state_t             state_q;
	entry_t             win_q [SUBINTERVALS];
	logic [TIME_W-1:0]  newest_q;
	logic [CFG_W-1:0]   sub_q;
	logic [SEQ_W-1:0]   seq_q;
	logic [TIME_W-1:0]  time_q;
	logic [TIME_W-1:0]  diff_q;
	logic [WALK_W-1:0]  walk_q;
	logic [SUM_W-1:0]   exp_q;
	logic [SUM_W-1:0]   rcv_sum_q;
	logic [1:0]         rcv_sat_q;
	logic [SUM_W-1:0]   miss_q;
	logic               any_q;
	logic [SEQ_W-1:0]   firstu_q;
	logic [SEQ_W-1:0]   lastu_q;
	logic [SEQ_W-1:0]   prev_last_q;
	logic [RATE_W-1:0]  rate_q;
	logic               unav_q;
	logic               m_tvalid_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	// per-entry accumulate unit, always looking at entry 0 of the rotating window
	entry_t           head;
	logic [SEQ_W-1:0] span;
	logic [SEQ_W-1:0] win_span;
	logic [SUM_W-1:0] over;
	logic             link;
	logic [SUM_W-1:0] exp_walk;
	logic [1:0]       sat_walk;
	logic [SUM_W-1:0] exp_fin;

	assign head     = win_q[0];
	assign span     = head.last - head.first + SEQ_W'(1);
	assign over     = (head.cnt > CNT_W'(span)) ? (head.cnt[SUM_W-1:0] - SUM_W'(span)) : '0;
	assign link     = (walk_q != '0) && (prev_last_q == head.first);
	assign exp_walk = exp_q + over + SUM_W'(link);
	assign sat_walk = (head.cnt >= CNT_W'(2)) ? 2'd2 :
		(rcv_sat_q == 2'd2) ? 2'd2 : rcv_sat_q + 2'(head.cnt[0]);
	assign win_span = lastu_q - firstu_q;
	assign exp_fin  = exp_q + SUM_W'(win_span) + SUM_W'(1);

	assign div_req.start = (state_q == ST_DIVGO);
	assign div_req.numer = NUM_W'(miss_q) * PCT_X2 + NUM_W'(exp_q);
	assign div_req.denom = {exp_q, 1'b0};

	perw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			for (int i = 0; i < SUBINTERVALS; i++) begin
				win_q[i] <= '0;
			end
			newest_q    <= '0;
			sub_q       <= SUBINT_MS_RST;
			seq_q       <= '0;
			time_q      <= '0;
			diff_q      <= '0;
			walk_q      <= '0;
			exp_q       <= '0;
			rcv_sum_q   <= '0;
			rcv_sat_q   <= '0;
			miss_q      <= '0;
			any_q       <= 1'b0;
			firstu_q    <= '0;
			lastu_q     <= '0;
			prev_last_q <= '0;
			rate_q      <= '0;
			unav_q      <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				sub_q <= cfg_data;
			end
			if (state_q == ST_OUT) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						seq_q   <= s_tdata[SEQ_W-1:0];
						time_q  <= s_tdata[SEQ_W +: TIME_W];
						diff_q  <= s_tdata[SEQ_W +: TIME_W] - newest_q;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (diff_q[TIME_W-1]) begin
						// time moved back: restart the newest entry
						win_q[SUBINTERVALS-1].first <= seq_q;
						win_q[SUBINTERVALS-1].last  <= seq_q;
						win_q[SUBINTERVALS-1].cnt   <= CNT_W'(1);
						newest_q <= time_q;
						state_q  <= ST_IDLE;
					end else if (diff_q >= TIME_W'(sub_q)) begin
						// hold until the previous result transaction is gone
						if (!m_tvalid_q || m_tready) begin
							walk_q    <= '0;
							exp_q     <= '0;
							rcv_sum_q <= '0;
							rcv_sat_q <= '0;
							any_q     <= 1'b0;
							state_q   <= ST_WALK;
						end
					end else begin
						win_q[SUBINTERVALS-1].last <= seq_q;
						if (win_q[SUBINTERVALS-1].cnt != '1) begin
							win_q[SUBINTERVALS-1].cnt <= win_q[SUBINTERVALS-1].cnt + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_WALK: begin
					if (head.cnt != '0) begin
						exp_q     <= exp_walk;
						rcv_sum_q <= rcv_sum_q + head.cnt[SUM_W-1:0];
						rcv_sat_q <= sat_walk;
						lastu_q   <= head.last;
						if (!any_q) begin
							any_q    <= 1'b1;
							firstu_q <= head.first;
						end
					end
					prev_last_q <= head.last;
					// full rotation leaves the window as it was
					for (int i = 0; i < SUBINTERVALS - 1; i++) begin
						win_q[i] <= win_q[i+1];
					end
					win_q[SUBINTERVALS-1] <= head;
					walk_q <= walk_q + 1'b1;
					if (walk_q == WALK_W'(SUBINTERVALS - 1)) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					if (rcv_sat_q != 2'd2) begin
						rate_q  <= '0;
						unav_q  <= 1'b1;
						state_q <= ST_OUT;
					end else if (exp_fin == '0) begin
						rate_q  <= PCT_MAX;
						unav_q  <= 1'b0;
						state_q <= ST_OUT;
					end else begin
						exp_q   <= exp_fin;
						miss_q  <= exp_fin - rcv_sum_q;
						state_q <= ST_DIVGO;
					end
				end
				ST_DIVGO: begin
					state_q <= ST_DIVWAIT;
				end
				ST_DIVWAIT: begin
					if (div_rsp.done) begin
						unav_q  <= 1'b0;
						rate_q  <= (div_rsp.quot > NUM_W'(PCT_MAX)) ? PCT_MAX :
							div_rsp.quot[RATE_W-1:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					for (int i = 0; i < SUBINTERVALS - 1; i++) begin
						win_q[i] <= win_q[i+1];
					end
					win_q[SUBINTERVALS-1].first <= seq_q;
					win_q[SUBINTERVALS-1].last  <= seq_q;
					win_q[SUBINTERVALS-1].cnt   <= CNT_W'(1);
					newest_q <= time_q;
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {1'b0, rate_q};
	assign m_tuser   = unav_q;

	`ASSERT_NOW(a_unav_zero, m_tvalid && m_tuser, m_tdata[RATE_W-1:0] == '0)
	`ASSERT_NOW(a_rate_cap, m_tvalid, m_tdata[RATE_W-1:0] <= PCT_MAX)
	`ASSERT_NOW(a_div_done_wait, div_rsp.done, state_q == ST_DIVWAIT)
	`ASSERT_NEXT(a_out_load, (state_q == ST_OUT) && !m_tvalid_q, m_tvalid_q && s_tready)

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import perw_pkg::*;

	localparam int WINDOW      = SUBINT_DEF;
	localparam int DRAIN_WAIT  = 60;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic              unavail;
	} per_result_t;

	class per_scoreboard;
		logic [SEQ_W-1:0]  first_seq [WINDOW];
		logic [SEQ_W-1:0]  last_seq [WINDOW];
		logic [CNT_W-1:0]  rx_count [WINDOW];
		logic [TIME_W-1:0] open_start;
		logic [CFG_W-1:0]  interval_ms;
		per_result_t       rate_q[$];
		int                fails;

		function new();
			for (int n = 0; n < WINDOW; n++) begin
				first_seq[n] = '0;
				last_seq[n] = '0;
				rx_count[n] = '0;
			end
			open_start = '0;
			interval_ms = SUBINT_MS_RST;
			fails = 0;
		endfunction

		function void set_interval(logic [CFG_W-1:0] v);
			interval_ms = v;
		endfunction

		function int pending();
			return rate_q.size();
		endfunction

		function void open_entry(logic [SEQ_W-1:0] seq, logic [TIME_W-1:0] t);
			first_seq[WINDOW-1] = seq;
			last_seq[WINDOW-1] = seq;
			rx_count[WINDOW-1] = CNT_W'(1);
			open_start = t;
		endfunction

		function per_result_t window_rate();
			int unsigned expct, recvd, span, fu, lu, missed, r, a, b;
			bit any;
			per_result_t res;
			expct = 0;
			recvd = 0;
			any = 0;
			fu = 0;
			lu = 0;
			for (int n = 0; n < WINDOW; n++) begin
				if (rx_count[n] != 0) begin
					a = 32'(last_seq[n]);
					b = 32'(first_seq[n]);
					span = (a - b + 1) & 127;
					recvd += 32'(rx_count[n]);
					if (rx_count[n] > span)
						expct = (expct + (rx_count[n] - span)) & 255;
					if (n > 0 && last_seq[n-1] == first_seq[n])
						expct = (expct + 1) & 255;
					if (!any) begin
						any = 1;
						fu = n;
					end
					lu = n;
				end
			end
			if (recvd < 2) begin
				res.rate = '0;
				res.unavail = 1'b1;
				return res;
			end
			a = 32'(last_seq[lu]);
			b = 32'(first_seq[fu]);
			expct = (expct + ((a - b) & 127) + 1) & 255;
			missed = (expct - recvd) & 255;
			if (expct == 0) begin
				r = 100;
			end else begin
				r = (missed * 200 + expct) / (2 * expct);
				if (r > 100)
					r = 100;
			end
			res.rate = r[RATE_W-1:0];
			res.unavail = 1'b0;
			return res;
		endfunction

		function void note_message(logic [SEQ_W-1:0] seq, logic [TIME_W-1:0] t);
			logic [TIME_W-1:0] diff;
			diff = t - open_start;
			if (diff[TIME_W-1]) begin
				open_entry(seq, t);
			end else if (diff >= {16'h0, interval_ms}) begin
				rate_q.push_back(window_rate());
				for (int n = 1; n < WINDOW; n++) begin
					first_seq[n-1] = first_seq[n];
					last_seq[n-1] = last_seq[n];
					rx_count[n-1] = rx_count[n];
				end
				open_entry(seq, t);
			end else begin
				last_seq[WINDOW-1] = seq;
				if (rx_count[WINDOW-1] != 16'hFFFF)
					rx_count[WINDOW-1] = rx_count[WINDOW-1] + 1'b1;
			end
		endfunction

		function void check_result(logic [RATE_W-1:0] rate, logic unavail);
			per_result_t e;
			if (rate_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual rate %0d unavailable %0d",
					$time, rate, unavail);
				fails++;
				return;
			end
			e = rate_q.pop_front();
			if (rate !== e.rate) begin
				$display("%0t: error_rate mismatch, expected %0d actual %0d",
					$time, e.rate, rate);
				fails++;
			end
			if (unavail !== e.unavail) begin
				$display("%0t: unavailable mismatch, expected %0d actual %0d",
					$time, e.unavail, unavail);
				fails++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	per_scoreboard     sb;
	int                tx_max = 9;
	int                rx_max = 9;
	int                rx_wait = 0;
	int                stall_cycles = 0;
	logic [TIME_W-1:0] now_ms = '0;
	logic [SEQ_W-1:0]  seq_now = '0;

	packet_error_rate_window_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// result side: random stall before each transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tdata[RATE_W-1:0], m_tuser);
				rx_wait = $urandom_range(0, rx_max);
				if (rx_wait == 0) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					rx_wait = rx_wait - 1;
				end
			end else if (!m_tready) begin
				if (rx_wait == 0)
					m_tready <= 1'b1;
				else
					rx_wait = rx_wait - 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("testbench failed");
				$finish;
			end
		end
	end

	task automatic send_msg(input logic [SEQ_W-1:0] seq, input logic [TIME_W-1:0] t);
		int gap;
		gap = $urandom_range(0, tx_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= {1'b0, t, seq};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_message(seq, t);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_interval(input logic [CFG_W-1:0] v);
		drain();
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_interval(v);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int count, input logic [CFG_W-1:0] iv);
		int unsigned ivu, step, kind;
		ivu = 32'(iv);
		step = (ivu / 3 == 0) ? 1 : ivu / 3;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				tx_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
				rx_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
			end
			if ($urandom_range(0, 49) == 0) begin
				s_tvalid <= 1'b0;
				while (sb.pending() != 0) @(posedge clk);
			end
			kind = $urandom_range(0, 99);
			if (kind < 80)
				seq_now = seq_now + SEQ_W'(1);
			else if (kind < 90)
				seq_now = seq_now + SEQ_W'($urandom_range(2, 20));
			else if (kind < 95)
				seq_now = SEQ_W'($urandom_range(0, 127));
			kind = $urandom_range(0, 99);
			if (kind < 70)
				now_ms = now_ms + $urandom_range(0, step);
			else if (kind < 85)
				now_ms = now_ms + ivu + $urandom_range(0, ivu);
			else if (kind < 93)
				now_ms = now_ms - $urandom_range(1, ivu + 1);
			else
				now_ms = $urandom();
			send_msg(seq_now, now_ms);
		end
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: startup, time moving back, time wrap, bit patterns
		send_msg(7'd0, 32'd0);
		send_msg(7'd127, 32'd50);
		send_msg(7'd1, 32'd99);
		send_msg(7'd2, 32'd100);
		send_msg(7'd3, 32'd99);
		send_msg(7'd4, 32'd150);
		send_msg(7'd127, 32'd199);
		send_msg(7'd0, 32'hFFFF_FFFF);
		send_msg(7'd1, 32'h0000_0063);
		send_msg(7'd64, 32'h7FFF_FFFF);
		send_msg(7'd65, 32'h8000_0000);
		send_msg(7'd0, 32'h0000_0000);
		send_msg(7'd127, 32'h0000_0000);
		send_msg(7'd0, 32'h5555_5555);
		send_msg(7'd127, 32'hAAAA_AAAA);
		send_msg(7'd0, 32'hAAAA_AAAA + 32'd100);

		// zero length: every message rolls over, fill window with seq 1..15 then 0
		write_interval(16'd0);
		now_ms = 32'd1000;
		for (int k = 1; k <= 16; k++) begin
			now_ms = now_ms + 1;
			send_msg(k[SEQ_W-1:0] & 7'h0F, now_ms);
		end

		// repeated seq 0 makes the expected total wrap to zero
		write_interval(16'd1000);
		for (int k = 0; k < 128; k++)
			send_msg(7'd0, now_ms);
		now_ms = now_ms + 1000;
		send_msg(7'd5, now_ms);

		// many messages back to back in one long subinterval
		write_interval(16'hFFFF);
		tx_max = 0;
		rx_max = 0;
		now_ms = now_ms + 70000;
		seq_now = 7'd10;
		send_msg(seq_now, now_ms);
		for (int k = 0; k < 60; k++) begin
			seq_now = seq_now + SEQ_W'(1);
			send_msg(seq_now, now_ms);
		end
		now_ms = now_ms + 32'hFFFF;
		send_msg(seq_now, now_ms);
		tx_max = 9;
		rx_max = 9;

		write_interval(16'd1);
		run_random(100, 16'd1);
		write_interval(16'hFFFF);
		run_random(100, 16'hFFFF);
		write_interval(16'd7);
		run_random(110, 16'd7);
		write_interval(SUBINT_MS_RST);
		run_random(110, SUBINT_MS_RST);
		begin
			logic [CFG_W-1:0] iv;
			iv = CFG_W'($urandom_range(2, 65534));
			write_interval(iv);
			run_random(100, iv);
		end
		write_interval(16'd0);
		run_random(100, 16'd0);
		write_interval(16'd25);
		run_random(100, 16'd25);

		drain();
		if (sb.fails == 0 && sb.pending() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
